### sv/tlfk_pkg.sv
`default_nettype none
package tlfk_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int ANG_FULL      = 23040;
  localparam int ANG_HALF      = 11520;
  localparam int ANG_QUARTER   = 5760;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [18:0] K_Q24 = 19'd292809;

  // Register indexes of the configuration port.
  localparam logic [0:0] REG_LOWER_ARM = 1'b0;
  localparam logic [0:0] REG_UPPER_ARM = 1'b1;

  // CORDIC word widths: Q30 vector plus growth, angle in degrees * 2^22.
  localparam int XW = 34;
  localparam int ZW = 32;

  typedef logic signed [XW-1:0] vec_t;
  typedef logic signed [ZW-1:0] ang_t;

  // One CORDIC lane item moving down the chain.
  typedef struct packed {
    vec_t x;
    vec_t y;
    ang_t z;
    logic neg;
  } lane_t;

  // Side data that rides along the chain with each item.
  typedef struct packed {
    logic        vld;
    logic signed [16:0] tr;
    logic signed [16:0] pr;
  } side_t;

  // atan(2^-i) in degrees * 2^22.
  function automatic ang_t atan_deg(input logic [4:0] i);
    ang_t v;
    begin
      unique case (i)
        5'd0:  v = 32'sd188743680;
        5'd1:  v = 32'sd111421900;
        5'd2:  v = 32'sd58872272;
        5'd3:  v = 32'sd29884485;
        5'd4:  v = 32'sd15000234;
        5'd5:  v = 32'sd7507429;
        5'd6:  v = 32'sd3754631;
        5'd7:  v = 32'sd1877430;
        5'd8:  v = 32'sd938729;
        5'd9:  v = 32'sd469366;
        5'd10: v = 32'sd234683;
        5'd11: v = 32'sd117342;
        5'd12: v = 32'sd58671;
        5'd13: v = 32'sd29335;
        5'd14: v = 32'sd14668;
        5'd15: v = 32'sd7334;
        5'd16: v = 32'sd3667;
        5'd17: v = 32'sd1833;
        5'd18: v = 32'sd917;
        5'd19: v = 32'sd458;
        5'd20: v = 32'sd229;
        5'd21: v = 32'sd115;
        5'd22: v = 32'sd57;
        5'd23: v = 32'sd29;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // Reduce an angle in 1/64 degree (17 bit) into [-90, 90] with a fold flag,
  // and return the seed lane item.
  function automatic lane_t seed(input logic signed [16:0] a);
    logic signed [17:0] r, off;
    lane_t l;
    begin
      r = {a[16], a};
      // Pick the multiple of 360 degrees that brings the angle into [-180, 180).
      priority if (r >= 18'(3 * ANG_FULL - ANG_HALF)) off = 18'(3 * ANG_FULL);
      else if (r >= 18'(2 * ANG_FULL - ANG_HALF))     off = 18'(2 * ANG_FULL);
      else if (r >= 18'(ANG_HALF))                    off = 18'(ANG_FULL);
      else if (r >= -18'(ANG_HALF))                   off = '0;
      else if (r >= -18'(ANG_FULL + ANG_HALF))        off = -18'(ANG_FULL);
      else if (r >= -18'(2 * ANG_FULL + ANG_HALF))    off = -18'(2 * ANG_FULL);
      else                                            off = -18'(3 * ANG_FULL);
      r = r - off;
      l.neg = 1'b0;
      if (r > 18'(ANG_QUARTER)) begin
        r = r - 18'(ANG_HALF);
        l.neg = 1'b1;
      end else if (r < -18'(ANG_QUARTER)) begin
        r = r + 18'(ANG_HALF);
        l.neg = 1'b1;
      end
      l.x = CORDIC_GAIN_Q30;
      l.y = '0;
      l.z = ZW'(r) <<< 16;
      return l;
    end
  endfunction

  // Saturate a 64 bit value to 23 bits.
  function automatic logic signed [22:0] sat23(input logic signed [63:0] v);
    begin
      if (v > 64'sd4194303) return 23'sd4194303;
      else if (v < -64'sd4194304) return -23'sd4194304;
      else return v[22:0];
    end
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [63:0] v);
    begin
      if (v > 64'sd131071) return 18'sd131071;
      else if (v < -64'sd131072) return -18'sd131072;
      else return v[17:0];
    end
  endfunction

endpackage
`default_nettype wire

### sv/tlfk_cell.sv
`default_nettype none
// One CORDIC micro-rotation for both angle lanes, registered.
module tlfk_cell (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [4:0]        idx,
  input  wire tlfk_pkg::lane_t   a_in,
  input  wire tlfk_pkg::lane_t   b_in,
  input  wire tlfk_pkg::side_t   s_in,
  input  wire logic              rst_n,
  output tlfk_pkg::lane_t        a_out,
  output tlfk_pkg::lane_t        b_out,
  output tlfk_pkg::side_t        s_out
);

  tlfk_pkg::lane_t a_nxt, b_nxt, a_r, b_r;
  logic               vld_r;
  logic signed [16:0] tr_r, pr_r;

  function automatic tlfk_pkg::lane_t rot(input tlfk_pkg::lane_t l, input logic [4:0] i);
    tlfk_pkg::lane_t o;
    tlfk_pkg::vec_t  dx, dy;
    begin
      dx = l.x >>> i;
      dy = l.y >>> i;
      o.neg = l.neg;
      if (!l.z[tlfk_pkg::ZW-1]) begin
        o.x = l.x - dy;
        o.y = l.y + dx;
        o.z = l.z - tlfk_pkg::atan_deg(i);
      end else begin
        o.x = l.x + dy;
        o.y = l.y - dx;
        o.z = l.z + tlfk_pkg::atan_deg(i);
      end
      return o;
    end
  endfunction

  assign a_nxt = rot(a_in, idx);
  assign b_nxt = rot(b_in, idx);

  // Payload advances whenever the chain moves.
  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      tr_r <= s_in.tr;
      pr_r <= s_in.pr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= s_in.vld;
    end
  end

  assign a_out = a_r;
  assign b_out = b_r;
  assign s_out = {vld_r, tr_r, pr_r};

endmodule
`default_nettype wire

### sv/tlfk_post.sv
`default_nettype none
// Back end: fold, length products, sums, rate products, scaling by k,
// rounding, zero check and saturation, in four registered stages.
module tlfk_post (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire tlfk_pkg::lane_t     a_in,
  input  wire tlfk_pkg::lane_t     b_in,
  input  wire tlfk_pkg::side_t     s_in,
  input  wire logic [15:0]         l1,
  input  wire logic [15:0]         l2,
  output logic                     vld,
  output logic signed [17:0]       pos_x,
  output logic signed [17:0]       pos_y,
  output logic signed [22:0]       vel_x,
  output logic signed [22:0]       vel_y
);

  // Stage 1: folded cos/sin times lengths.
  logic signed [50:0] p1c_r, p1s_r, p2c_r, p2s_r;
  logic signed [16:0] tr1_r, pr1_r;
  logic               v1_r;
  tlfk_pkg::vec_t c1, s1, c2, s2;

  assign c1 = a_in.neg ? -a_in.x : a_in.x;
  assign s1 = a_in.neg ? -a_in.y : a_in.y;
  assign c2 = b_in.neg ? -b_in.x : b_in.x;
  assign s2 = b_in.neg ? -b_in.y : b_in.y;

  always_ff @(posedge clk) begin
    if (en) begin
      p1c_r <= 51'(c1) * $signed({1'b0, l1});
      p1s_r <= 51'(s1) * $signed({1'b0, l1});
      p2c_r <= 51'(c2) * $signed({1'b0, l2});
      p2s_r <= 51'(s2) * $signed({1'b0, l2});
      tr1_r <= s_in.tr;
      pr1_r <= s_in.pr;
    end
  end

  // Stage 2: rounded shifts and position sums.
  logic signed [28:0] ec_r, es_r, xs_r, ys_r;
  logic signed [28:0] ec, es, a1, b1;
  logic signed [16:0] tr2_r, pr2_r;
  logic               v2_r;

  assign ec = 29'((p2c_r + 51'sd2097152) >>> 22);
  assign es = 29'((p2s_r + 51'sd2097152) >>> 22);
  assign a1 = 29'((p1s_r + 51'sd2097152) >>> 22);
  assign b1 = 29'((p1c_r + 51'sd2097152) >>> 22);

  always_ff @(posedge clk) begin
    if (en) begin
      ec_r  <= ec;
      es_r  <= es;
      xs_r  <= a1 + es;
      ys_r  <= b1 + ec;
      tr2_r <= tr1_r;
      pr2_r <= pr1_r;
    end
  end

  // Stage 3: rate products summed.
  logic signed [47:0] vxs_r, vys_r;
  logic signed [28:0] xs3_r, ys3_r;
  logic               v3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      vxs_r <= 48'(pr2_r) * 48'(ec_r) + 48'(tr2_r) * 48'(ys_r);
      vys_r <= -(48'(pr2_r) * 48'(es_r)) - 48'(tr2_r) * 48'(xs_r);
      xs3_r <= xs_r;
      ys3_r <= ys_r;
    end
  end

  // Stage 4: scale by k, round, zero check and saturate.
  logic signed [66:0] kx, ky;
  logic signed [20:0] px, py;
  assign kx = 67'(vxs_r) * $signed({1'b0, tlfk_pkg::K_Q24});
  assign ky = 67'(vys_r) * $signed({1'b0, tlfk_pkg::K_Q24});
  assign px = 21'((xs3_r + 29'sd128) >>> 8);
  assign py = 21'((ys3_r + 29'sd128) >>> 8);

  logic signed [28:0] rx, ry;
  assign rx = 29'((kx + 67'sd137438953472) >>> 38);
  assign ry = 29'((ky + 67'sd137438953472) >>> 38);

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x <= tlfk_pkg::sat18(64'(px));
      pos_y <= tlfk_pkg::sat18(64'(py));
      if (px == '0 && py == '0) begin
        vel_x <= '0;
        vel_y <= '0;
      end else begin
        vel_x <= tlfk_pkg::sat23(64'(rx));
        vel_y <= tlfk_pkg::sat23(64'(ry));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vld  <= 1'b0;
    end else if (en) begin
      v1_r <= s_in.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vld  <= v3_r;
    end
  end

endmodule
`default_nettype wire

### sv/two_link_forward_kinematics_core.sv
`default_nettype none
// Throughput: one item per cycle; the chain of CORDIC cells and the back end
// advance together whenever the output register is free or being taken.
// Reset: synchronous active-low rst_n clears all valid flags and sets both
// arm lengths to 8192.
module two_link_forward_kinematics_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // shoulder_angle[15:0], elbow_angle[31:16], shoulder_rate[48:32], elbow_rate[65:49]
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // pos_x[17:0], pos_y[35:18], vel_x[58:36], vel_y[81:59]
  output logic [87:0]      out_tdata
);

  localparam int N = tlfk_pkg::CORDIC_STAGES;

  logic [15:0] l1_r, l2_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r <= 16'd8192;
      l2_r <= 16'd8192;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tlfk_pkg::REG_LOWER_ARM: l1_r <= cfg_wdata;
        tlfk_pkg::REG_UPPER_ARM: l2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances when the output slot is empty or drained.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic signed [15:0] t, p;
  assign t = in_tdata[15:0];
  assign p = in_tdata[31:16];

  tlfk_pkg::lane_t a_ch [N+1];
  tlfk_pkg::lane_t b_ch [N+1];
  tlfk_pkg::side_t s_ch [N+1];

  assign a_ch[0]     = tlfk_pkg::seed({t[15], t});
  assign b_ch[0]     = tlfk_pkg::seed(17'(t) + 17'(p));
  assign s_ch[0].vld = in_tvalid;
  assign s_ch[0].tr  = in_tdata[48:32];
  assign s_ch[0].pr  = in_tdata[65:49];

  // Chain of micro-rotation cells.
  for (genvar g = 0; g < N; g++) begin : g_cell
    tlfk_cell u_cell (
      .clk   (clk),
      .en    (en),
      .idx   (5'(g)),
      .a_in  (a_ch[g]),
      .b_in  (b_ch[g]),
      .s_in  (s_ch[g]),
      .rst_n (rst_n),
      .a_out (a_ch[g+1]),
      .b_out (b_ch[g+1]),
      .s_out (s_ch[g+1])
    );
  end

  logic signed [17:0] pos_x, pos_y;
  logic signed [22:0] vel_x, vel_y;

  tlfk_post u_post (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .a_in  (a_ch[N]),
    .b_in  (b_ch[N]),
    .s_in  (s_ch[N]),
    .l1    (l1_r),
    .l2    (l2_r),
    .vld   (out_tvalid),
    .pos_x (pos_x),
    .pos_y (pos_y),
    .vel_x (vel_x),
    .vel_y (vel_y)
  );

  assign out_tdata = {6'd0, vel_y, vel_x, pos_y, pos_x};

endmodule
`default_nettype wire

### sv/tlfk_checker.sv
`default_nettype none
// Port-level checks on the core.
module tlfk_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [87:0] out_tdata
);

  // The core takes input exactly when its output slot can move.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready)) else $error("ready mismatch");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Zero position implies zero velocity.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[35:0] == '0 |-> out_tdata[81:36] == '0)
    else $error("velocity at zero position");

  // Pad bits stay clear.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[87:82] == '0) else $error("pad bits set");

endmodule

bind two_link_forward_kinematics_core tlfk_checker u_tlfk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
